// ===== src/tdst_pkg.sv =====
package tdst_pkg;

  // Field widths of one item.
  localparam int unsigned OP_W   = 2;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned INTV_W = 16;
  localparam int unsigned CNT_W  = 16;

  // One table entry: {periodic, interval, count}.
  localparam int unsigned ENTRY_W = 1 + INTV_W + CNT_W;

  localparam int unsigned NUM_TIMERS_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_FLUSH = 3'b100
  } state_e;

endpackage

// ===== src/tdst_ram.sv =====
module tdst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tick_driven_soft_timer_table_core.sv =====
// Table of NumTimers software timers, one per slot. Each accepted item is an op: add loads a
// slot with an interval and a reload mode and restarts its counter, remove drops one slot,
// clear drops all, and tick advances every live timer. Add, remove and clear leave in_stall_o low.
// A tick walks the table in slot order through an entry RAM with one read and one write
// port, one slot per cycle unless the output side stalls, in a two-stage read/evaluate pipe:
// in_stall_o stays high from a taken tick until the walk and the flush of the held slot
// are done, also while the output side stalls. A slot whose counter equals its interval
// fires (period is interval + 1 ticks) and then restarts or, in one-shot mode, drops out;
// others count up, wrapping at 16 bits. Each fired slot gives one result in slot order;
// the final one of a tick carries last. One fired slot is held back until the next one
// (or the end of the walk) is known, which is how last gets set.
module tick_driven_soft_timer_table_core #(
  parameter int unsigned NumTimers = tdst_pkg::NUM_TIMERS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // item in
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tdst_pkg::op_e               op_i,
  input  logic [tdst_pkg::SLOT_W-1:0] slot_i,
  input  logic [tdst_pkg::INTV_W-1:0] interval_i,
  input  logic                        auto_reload_i,
  // item out
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tdst_pkg::SLOT_W-1:0] fired_slot_o,
  output logic                        last_o
);

  import tdst_pkg::*;

  localparam int unsigned IdxW = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumTimers - 1);

  // control state
  state_e               state_q, state_d;
  logic [NumTimers-1:0] valid_q, valid_d;
  logic                 rd_act_q, rd_act_d;     // read stage still issuing
  logic                 ev_vld_q, ev_vld_d;     // evaluate stage holds a slot
  logic                 pend_vld_q, pend_vld_d; // fired slot held back for last
  logic                 out_vld_q, out_vld_d;

  // payload
  logic [IdxW-1:0]   rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]   ev_idx_q, ev_idx_d;
  logic [SLOT_W-1:0] pend_slot_q, pend_slot_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic              out_last_q, out_last_d;

  // entry RAM
  logic               ram_we, ram_re;
  logic [IdxW-1:0]    ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic              ev_periodic;
  logic [INTV_W-1:0] ev_intv;
  logic [CNT_W-1:0]  ev_cnt;

  logic            in_acc, out_acc, can_push;
  logic            slot_ok;
  logic [IdxW-1:0] slot_idx;
  logic            ev_live, ev_fire, ev_stall, advance;

  tdst_ram #(
    .Width(ENTRY_W),
    .Depth(NumTimers)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(rd_idx_q),
    .rdata_o(ram_rdata)
  );

  assign ev_periodic = ram_rdata[ENTRY_W-1];
  assign ev_intv     = ram_rdata[CNT_W +: INTV_W];
  assign ev_cnt      = ram_rdata[CNT_W-1:0];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_vld_q && !out_stall_i;
  assign can_push   = !out_vld_q || !out_stall_i;

  // slots at or beyond the table size are ignored by add and remove
  assign slot_ok  = (32'(slot_i) < NumTimers);
  assign slot_idx = IdxW'(slot_i);

  // evaluate stage: only valid slots take part
  assign ev_live  = ev_vld_q && valid_q[ev_idx_q];
  assign ev_fire  = ev_live && (ev_cnt == ev_intv);
  // a second fire must push the held one out first; wait if the output is full
  assign ev_stall = ev_fire && pend_vld_q && !can_push;
  assign advance  = (state_q == S_WALK) && !ev_stall;

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    rd_act_d    = rd_act_q;
    rd_idx_d    = rd_idx_q;
    ev_vld_d    = ev_vld_q;
    ev_idx_d    = ev_idx_q;
    pend_vld_d  = pend_vld_q;
    pend_slot_d = pend_slot_q;
    out_vld_d   = out_vld_q;
    out_slot_d  = out_slot_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = ev_idx_q;
    ram_wdata   = {ev_periodic, ev_intv, CNT_W'(ev_cnt + 1'b1)};

    if (out_acc) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (op_i)
            OP_TICK: begin
              state_d  = S_WALK;
              rd_act_d = 1'b1;
              rd_idx_d = '0;
            end
            OP_ADD: begin
              if (slot_ok) begin
                ram_we            = 1'b1;
                ram_waddr         = slot_idx;
                ram_wdata         = {auto_reload_i, interval_i, {CNT_W{1'b0}}};
                valid_d[slot_idx] = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (slot_ok) begin
                valid_d[slot_idx] = 1'b0;
              end
            end
            OP_CLEAR: begin
              valid_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_WALK: begin
        if (advance) begin
          // read stage
          ram_re   = rd_act_q;
          ev_vld_d = rd_act_q;
          ev_idx_d = rd_idx_q;
          if (rd_act_q) begin
            if (rd_idx_q == LastIdx) begin
              rd_act_d = 1'b0;
            end else begin
              rd_idx_d = rd_idx_q + 1'b1;
            end
          end
          // evaluate stage, write back to the slot just read
          if (ev_live) begin
            if (ev_fire) begin
              if (pend_vld_q) begin
                out_vld_d  = 1'b1;
                out_slot_d = pend_slot_q;
                out_last_d = 1'b0;
              end
              pend_vld_d  = 1'b1;
              pend_slot_d = SLOT_W'(ev_idx_q);
              if (ev_periodic) begin
                ram_we    = 1'b1;
                ram_wdata = {ev_periodic, ev_intv, {CNT_W{1'b0}}};
              end else begin
                valid_d[ev_idx_q] = 1'b0;
              end
            end else begin
              ram_we = 1'b1;
            end
          end
          if (!rd_act_q && !ev_vld_q) begin
            state_d = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        // the held slot, if any, is the final result of this tick
        if (!pend_vld_q) begin
          state_d = S_IDLE;
        end else if (can_push) begin
          out_vld_d  = 1'b1;
          out_slot_d = pend_slot_q;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      valid_q    <= '0;
      rd_act_q   <= 1'b0;
      ev_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      rd_act_q   <= rd_act_d;
      ev_vld_q   <= ev_vld_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    ev_idx_q    <= ev_idx_d;
    pend_slot_q <= pend_slot_d;
    out_slot_q  <= out_slot_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o  = out_vld_q;
  assign fired_slot_o = out_slot_q;
  assign last_o       = out_last_q;

  // idle means the walk pipe and the held-back slot are empty
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!rd_act_q && !ev_vld_q && !pend_vld_q))
    else $error("walk state left over in idle");

  // the walk only waits when a held slot has to go out first
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_stall |-> (pend_vld_q && out_vld_q && (state_q == S_WALK)))
    else $error("walk stalled without a held slot");

  // a stalled evaluate stage keeps its slot
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_stall |=> (ev_vld_q && $stable(ev_idx_q) && pend_vld_q))
    else $error("evaluate stage moved during stall");

  // flushing the held slot presents it as the final result
  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FLUSH) && pend_vld_q && can_push)
      |=> (out_vld_q && out_last_q && (state_q == S_IDLE)))
    else $error("final result of tick not marked last");

endmodule

// ===== tb/tb_tick_driven_soft_timer_table_core.sv =====
module tb_tick_driven_soft_timer_table_core;
  import tdst_pkg::*;

  localparam int unsigned NTIM         = NUM_TIMERS_DEF;
  // Longest run of cycles with no item moving on either side before we call it hung.
  // Must clear the long receiver hold below plus a full stalled walk.
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;
  // Drain time after the last owed item, longer than a tick walk, to show stray items.
  localparam int unsigned DRAIN_CYCLES = 2 * NTIM + 8;
  localparam int unsigned ITEMS_PER_PHASE = 110;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  op_e                 op_i;
  logic [SLOT_W-1:0]   slot_i;
  logic [INTV_W-1:0]   interval_i;
  logic                auto_reload_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [SLOT_W-1:0]   fired_slot_o;
  logic                last_o;

  tick_driven_soft_timer_table_core #(
    .NumTimers(NTIM)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .slot_i       (slot_i),
    .interval_i   (interval_i),
    .auto_reload_i(auto_reload_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .fired_slot_o (fired_slot_o),
    .last_o       (last_o)
  );

  // One fired-slot item as it should leave the block.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              last;
  } fire_t;

  // Directed row. n_fire < 0: take whatever the timer model predicts.
  // n_fire >= 0: the fired slots are typed in (f0 then f1, last on the final one).
  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic [INTV_W-1:0] intv;
    logic              reload;
    int                n_fire;
    logic [SLOT_W-1:0] f0;
    logic [SLOT_W-1:0] f1;
  } row_t;

  row_t plan [20] = '{
    // empty table: tick, remove of a dead slot and clear do nothing
    '{OP_TICK,   4'd0,  16'h0000, 1'b0,  0, 4'd0,  4'd0},
    '{OP_REMOVE, 4'd5,  16'h0000, 1'b0,  0, 4'd0,  4'd0},
    '{OP_CLEAR,  4'd0,  16'h0000, 1'b0,  0, 4'd0,  4'd0},
    // one-shot with interval 0 fires on the first tick and drops out
    '{OP_ADD,    4'd0,  16'h0000, 1'b0,  0, 4'd0,  4'd0},
    '{OP_TICK,   4'd0,  16'h0000, 1'b0,  1, 4'd0,  4'd0},
    '{OP_TICK,   4'd0,  16'h0000, 1'b0,  0, 4'd0,  4'd0},
    // top slot periodic every tick, slot 3 every second tick
    '{OP_ADD,    4'd15, 16'h0000, 1'b1,  0, 4'd0,  4'd0},
    '{OP_ADD,    4'd3,  16'h0001, 1'b1,  0, 4'd0,  4'd0},
    '{OP_TICK,   4'd0,  16'h0000, 1'b0,  1, 4'd15, 4'd0},
    '{OP_TICK,   4'd0,  16'h0000, 1'b0,  2, 4'd3,  4'd15},
    // reload of a live slot with the largest interval restarts its count
    '{OP_ADD,    4'd3,  16'hFFFF, 1'b0,  0, 4'd0,  4'd0},
    '{OP_TICK,   4'd0,  16'h0000, 1'b0,  1, 4'd15, 4'd0},
    '{OP_REMOVE, 4'd15, 16'h0000, 1'b0,  0, 4'd0,  4'd0},
    '{OP_TICK,   4'd0,  16'h0000, 1'b0,  0, 4'd0,  4'd0},
    // period of interval + 1 ticks
    '{OP_ADD,    4'd10, 16'h0002, 1'b1,  0, 4'd0,  4'd0},
    '{OP_TICK,   4'd0,  16'h0000, 1'b0, -1, 4'd0,  4'd0},
    '{OP_TICK,   4'd0,  16'h0000, 1'b0, -1, 4'd0,  4'd0},
    '{OP_TICK,   4'd0,  16'h0000, 1'b0, -1, 4'd0,  4'd0},
    '{OP_CLEAR,  4'd0,  16'h0000, 1'b0,  0, 4'd0,  4'd0},
    '{OP_TICK,   4'd0,  16'h0000, 1'b0,  0, 4'd0,  4'd0}
  };

  // Timer table as the testbench sees it.
  logic              tmr_live   [NTIM];
  logic [INTV_W-1:0] tmr_limit  [NTIM];
  logic              tmr_reload [NTIM];
  logic [CNT_W-1:0]  tmr_count  [NTIM];

  fire_t       tick_fires[$];   // fired slots of the item just applied
  fire_t       pending_fires[$]; // fired slots still owed by the block
  int unsigned n_errors;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          rx_hold_go;
  int unsigned quiet_cycles;

  // Apply one op to the table; a tick leaves its fired slots in tick_fires.
  function automatic void run_timers(op_e op, logic [SLOT_W-1:0] s,
                                     logic [INTV_W-1:0] iv, logic rl);
    tick_fires.delete();
    case (op)
      OP_ADD: begin
        if (s < NTIM) begin
          tmr_limit[s]  = iv;
          tmr_reload[s] = rl;
          tmr_count[s]  = '0;
          tmr_live[s]   = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (s < NTIM) tmr_live[s] = 1'b0;
      end
      OP_CLEAR: begin
        for (int i = 0; i < NTIM; i++) tmr_live[i] = 1'b0;
      end
      default: begin
        // tick: slot order, fire on count == interval, otherwise count up
        for (int i = 0; i < NTIM; i++) begin
          if (tmr_live[i]) begin
            if (tmr_count[i] == tmr_limit[i]) begin
              tick_fires.push_back('{slot: SLOT_W'(i), last: 1'b0});
              if (tmr_reload[i]) tmr_count[i] = '0;
              else tmr_live[i] = 1'b0;
            end else begin
              tmr_count[i] = tmr_count[i] + 1'b1;
            end
          end
        end
        if (tick_fires.size() > 0) tick_fires[tick_fires.size()-1].last = 1'b1;
      end
    endcase
  endfunction

  // Offer one item, hold it until taken, then book what it should produce.
  // n_fire >= 0 swaps in the typed-in fired slots for the predicted ones.
  task automatic send_item(op_e op, logic [SLOT_W-1:0] s, logic [INTV_W-1:0] iv,
                           logic rl, int n_fire = -1,
                           logic [SLOT_W-1:0] f0 = '0, logic [SLOT_W-1:0] f1 = '0);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    slot_i        <= s;
    interval_i    <= iv;
    auto_reload_i <= rl;
    do @(posedge clk_i); while (in_stall_o);
    run_timers(op, s, iv, rl);
    if (n_fire >= 0) begin
      tick_fires.delete();
      if (n_fire > 0) tick_fires.push_back('{slot: f0, last: n_fire == 1});
      if (n_fire > 1) tick_fires.push_back('{slot: f1, last: 1'b1});
    end
    foreach (tick_fires[k]) pending_fires.push_back(tick_fires[k]);
  endtask

  // Mostly ticks and adds with short intervals so timers keep firing; now and then
  // a full-range or extreme interval, a remove, or a clear.
  task automatic send_random();
    int unsigned pick;
    int unsigned ivsel;
    logic [INTV_W-1:0] iv;
    op_e op;
    pick  = $urandom_range(99);
    ivsel = $urandom_range(99);
    if (ivsel < 85)      iv = INTV_W'($urandom_range(6));
    else if (ivsel < 95) iv = INTV_W'($urandom);
    else if (ivsel < 98) iv = '1;
    else                 iv = '0;
    if (pick < 50)      op = OP_TICK;
    else if (pick < 84) op = OP_ADD;
    else if (pick < 96) op = OP_REMOVE;
    else                op = OP_CLEAR;
    send_item(op, SLOT_W'($urandom_range(NTIM - 1)), iv, $urandom_range(99) < 70);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls at rx_idle_pct, plus one long hold when asked, counted here.
  initial begin : rx_side
    int unsigned hold_left;
    bit          hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Compare every taken fired-slot item against the oldest one owed.
  always @(posedge clk_i) begin : out_check
    fire_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_fires.size() == 0) begin
        $display("%0t: unexpected item: fired_slot=%0d last=%0b",
                 $time, fired_slot_o, last_o);
        n_errors++;
      end else begin
        want = pending_fires.pop_front();
        if (fired_slot_o !== want.slot) begin
          $display("%0t: fired_slot mismatch: expected %0d, actual %0d",
                   $time, want.slot, fired_slot_o);
          n_errors++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last mismatch (slot %0d): expected %0b, actual %0b",
                   $time, want.slot, want.last, last_o);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: no item moving on either side for too long means the block hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, nothing moved for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    n_errors      = 0;
    tx_idle_pct   = 32;
    rx_idle_pct   = 76;
    rx_hold_go    = 1'b0;
    quiet_cycles  = 0;
    for (int i = 0; i < NTIM; i++) begin
      tmr_live[i]   = 1'b0;
      tmr_limit[i]  = '0;
      tmr_reload[i] = 1'b0;
      tmr_count[i]  = '0;
    end
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    op_i          <= OP_TICK;
    slot_i        <= '0;
    interval_i    <= '0;
    auto_reload_i <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, under the first idle mix.
    foreach (plan[r]) begin
      send_item(plan[r].op, plan[r].slot, plan[r].intv, plan[r].reload,
                plan[r].n_fire, plan[r].f0, plan[r].f1);
    end

    // Random part: sender-light/receiver-heavy, swapped, then no idling at all.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 32; rx_idle_pct = 76; end
        1: begin tx_idle_pct = 76; rx_idle_pct = 32; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      repeat (ITEMS_PER_PHASE) send_random();
      if (ph == 2) begin
        // Every slot fires on every tick, so each tick owes a full table of items.
        // The receiver then holds off while ticks keep coming, backing up the block.
        for (int s = 0; s < NTIM; s++) send_item(OP_ADD, SLOT_W'(s), '0, 1'b1);
        rx_hold_go = 1'b1;
        repeat (12) send_item(OP_TICK, '0, '0, 1'b0);
      end
    end
    in_valid_i <= 1'b0;

    while (pending_fires.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending_fires.size() != 0) begin
      $display("%0t: %0d fired-slot items never arrived", $time, pending_fires.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/tdst_pkg.sv
src/tdst_ram.sv
src/tick_driven_soft_timer_table_core.sv
tb/tb_tick_driven_soft_timer_table_core.sv
